### sv/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define CSK_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CSK_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/csk_pkg.sv
// types and constants of the comment and whitespace skipper
// no dependencies
package csk_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int SKIP_WIDTH  = 16;

   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] WS_LOW       = 8'd1;
   localparam logic [7:0] WS_HIGH      = 8'd32;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_PLAIN  = 3'd1,
      MODE_SLASH  = 3'd2,
      MODE_LINE   = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_BSTAR  = 3'd5,
      MODE_BSLASH = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_CONTENT = 2'd0,
      ST_EOT     = 2'd1,
      ST_NESTED  = 2'd2,
      ST_UNTERM  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       begin_run;
      logic       end_of_text;
   } in_word_type;

   typedef struct packed {
      logic                  valid;
      logic [SKIP_WIDTH-1:0] count;
      status_type            status;
   } step_result_type;

endpackage

### sv/comment_whitespace_skipper_top.sv
// top level of the comment and whitespace skipper
// depends on csk_pkg, csk_in_reg, csk_scan, csk_out_reg, assert_macros.svh
//
// channel  dir  handshake              payload
// req_     in   req_valid/req_ready    text_byte, begin_run, end_of_text
// rsp_     out  rsp_valid/rsp_ready    skipped_count, run_status
//
// one byte per cycle unless a result stalls; results pass input, then result register
// the scan step is combinational logic between the input and result registers
// synchronous reset puts the scanner idle with a zero count and empties both registers
// a stalled result holds the scan; the input register takes one more byte, then stalls
`include "assert_macros.svh"

module comment_whitespace_skipper_top
   import csk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_begin_run,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SKIP_WIDTH-1:0] rsp_skipped_count,
   output logic [1:0]            rsp_run_status
);

   in_word_type     req_word;
   in_word_type     word;
   logic            word_valid;
   logic            take;
   step_result_type result;
   mode_type        scan_mode;

   assign req_word.text_byte   = req_text_byte;
   assign req_word.begin_run   = req_begin_run;
   assign req_word.end_of_text = req_end_of_text;

   csk_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .take       (take),
      .word_valid (word_valid),
      .word       (word)
   );

   csk_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .word      (word),
      .result    (result),
      .scan_mode (scan_mode)
   );

   csk_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .word_valid        (word_valid),
      .result            (result),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_skipped_count (rsp_skipped_count),
      .rsp_run_status    (rsp_run_status)
   );

   `CSK_ASSERT_NEXT(a_idle_after_result, clock, reset, take && result.valid,
      scan_mode == MODE_IDLE, "scan not idle after a result")
   `CSK_ASSERT_NEXT(a_result_from_scan, clock, reset, !rsp_valid && !take,
      !rsp_valid, "result shown without a scanned word")
   `CSK_ASSERT_SAME(a_eot_status, clock, reset,
      take && result.valid && !word.end_of_text,
      result.status == ST_CONTENT || result.status == ST_NESTED,
      "end status without end of text")
   `CSK_ASSERT_SAME(a_ready_on_drain, clock, reset, rsp_ready, req_ready,
      "input stalled while results drain")

endmodule

### sv/csk_in_reg.sv
// input register of the skipper: holds one word until the scan stage takes it
// depends on csk_pkg
module csk_in_reg
   import csk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  in_word_type req_word,
   input  logic        take,
   output logic        word_valid,
   output in_word_type word
);

   logic        valid_ff;
   logic        valid_in;
   in_word_type word_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

### sv/csk_scan.sv
// scan mode and run count registers with the one-byte step logic
// depends on csk_pkg
module csk_scan
   import csk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  in_word_type     word,
   output step_result_type result,
   output mode_type        scan_mode
);

   mode_type               mode_ff;
   mode_type               mode_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   mode_type               m_cur;
   logic [COUNT_WIDTH-1:0] c_cur;
   logic [1:0]             add;
   logic [COUNT_WIDTH:0]   sum;
   logic                   active;
   logic                   fin;
   status_type             status;
   logic [31:0]            count_wide;

   always_comb begin
      m_cur   = word.begin_run ? MODE_PLAIN : mode_ff;
      c_cur   = word.begin_run ? '0 : count_ff;
      mode_in = m_cur;
      add     = 2'd0;
      active  = 1'b1;
      fin     = 1'b0;
      status  = ST_CONTENT;
      unique case (m_cur)
         MODE_PLAIN: begin
            if (word.text_byte == CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (word.text_byte >= WS_LOW && word.text_byte <= WS_HIGH) begin
               add = 2'd1;
            end else begin
               fin = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (word.text_byte == CHAR_STAR) begin
               add     = 2'd2;
               mode_in = MODE_BLOCK;
            end else if (word.text_byte == CHAR_SLASH) begin
               add     = 2'd2;
               mode_in = MODE_LINE;
            end else begin
               fin = 1'b1;
            end
         end
         MODE_LINE: begin
            add = 2'd1;
            if (word.text_byte == CHAR_NEWLINE) begin
               mode_in = MODE_PLAIN;
            end
         end
         MODE_BLOCK, MODE_BSTAR, MODE_BSLASH: begin
            add = 2'd1;
            if (m_cur == MODE_BSLASH && word.text_byte == CHAR_STAR) begin
               fin    = 1'b1;
               status = ST_NESTED;
            end else if (m_cur == MODE_BSTAR && word.text_byte == CHAR_SLASH) begin
               mode_in = MODE_PLAIN;
            end else if (word.text_byte == CHAR_STAR) begin
               mode_in = MODE_BSTAR;
            end else if (word.text_byte == CHAR_SLASH) begin
               mode_in = MODE_BSLASH;
            end else begin
               mode_in = MODE_BLOCK;
            end
         end
         default: begin
            // idle, or a code with no mode: byte is dropped
            active  = 1'b0;
            mode_in = MODE_IDLE;
         end
      endcase

      // end of text is judged on the mode after this byte
      if (active && !fin && word.end_of_text) begin
         fin = 1'b1;
         if (mode_in == MODE_BLOCK || mode_in == MODE_BSTAR || mode_in == MODE_BSLASH) begin
            status = ST_UNTERM;
         end else if (mode_in == MODE_SLASH) begin
            status = ST_CONTENT;
         end else begin
            status = ST_EOT;
         end
      end
      if (fin) begin
         mode_in = MODE_IDLE;
      end

      // saturating add, carry out means past the top
      sum      = {1'b0, c_cur} + {{(COUNT_WIDTH-1){1'b0}}, add};
      count_in = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   assign count_wide    = 32'(count_in);
   assign result.valid  = active && fin;
   assign result.count  = count_wide[SKIP_WIDTH-1:0];
   assign result.status = status;
   assign scan_mode     = mode_ff;

endmodule

### sv/csk_out_reg.sv
// result register of the skipper, refilled in the cycle it drains
// depends on csk_pkg
module csk_out_reg
   import csk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  word_valid,
   input  step_result_type       result,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SKIP_WIDTH-1:0] rsp_skipped_count,
   output logic [1:0]            rsp_run_status
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [SKIP_WIDTH-1:0] count_ff;
   status_type            status_ff;

   assign take = word_valid && (!valid_ff || rsp_ready);

   always_comb begin
      if (take) begin
         valid_in = result.valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         count_ff  <= result.count;
         status_ff <= result.status;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_skipped_count = count_ff;
   assign rsp_run_status    = status_ff;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// testbench for comment_whitespace_skipper_top: queued byte driver, result monitor and
// a cycle-free predictor of the skip runs; depends on csk_pkg and the skipper rtl
module tb;
   import csk_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_WORDS = 1650;

   typedef struct {
      in_word_type word;
      int          gap;
   } text_word_type;

   typedef struct packed {
      logic [SKIP_WIDTH-1:0] count;
      status_type            status;
   } skip_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_text_byte = '0;
   logic                  req_begin_run = 1'b0;
   logic                  req_end_of_text = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SKIP_WIDTH-1:0] rsp_skipped_count;
   logic [1:0]            rsp_run_status;

   text_word_type   pending_words[$];
   skip_result_type awaited_results[$];
   logic [7:0]      run_bytes[$];

   mode_type        scan_state = MODE_IDLE;
   longint unsigned skip_tally = 0;

   bit  burst = 1'b0;
   bit  word_taken = 1'b0;
   int  idle_spent = 0;
   int  accepted_words = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  steady_left = 0;
   bit  hold_done = 1'b0;

   comment_whitespace_skipper_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_begin_run     (req_begin_run),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_skipped_count (rsp_skipped_count),
      .rsp_run_status    (rsp_run_status)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void add_skipped(input int n);
      longint unsigned top;
      top = (longint'(1) << COUNT_WIDTH) - 1;
      skip_tally = (skip_tally + n > top) ? top : skip_tally + n;
   endfunction

   function automatic bit scan_byte(input logic [7:0] b, input logic br, input logic eot,
                                    output skip_result_type r);
      bit         closed;
      status_type st;
      closed   = 1'b0;
      st       = ST_CONTENT;
      r.count  = '0;
      r.status = ST_CONTENT;
      if (br) begin
         scan_state = MODE_PLAIN;
         skip_tally = 0;
      end
      case (scan_state)
         MODE_IDLE: return 1'b0;
         MODE_PLAIN: begin
            if (b == CHAR_SLASH) scan_state = MODE_SLASH;
            else if (b >= WS_LOW && b <= WS_HIGH) add_skipped(1);
            else closed = 1'b1;
         end
         MODE_SLASH: begin
            if (b == CHAR_STAR) begin
               add_skipped(2);
               scan_state = MODE_BLOCK;
            end else if (b == CHAR_SLASH) begin
               add_skipped(2);
               scan_state = MODE_LINE;
            end else begin
               closed = 1'b1;
            end
         end
         MODE_LINE: begin
            add_skipped(1);
            if (b == CHAR_NEWLINE) scan_state = MODE_PLAIN;
         end
         default: begin
            // inside a block comment every byte counts, closer included
            add_skipped(1);
            if (scan_state == MODE_BSLASH && b == CHAR_STAR) begin
               closed = 1'b1;
               st     = ST_NESTED;
            end else if (scan_state == MODE_BSTAR && b == CHAR_SLASH) begin
               scan_state = MODE_PLAIN;
            end else if (b == CHAR_STAR) begin
               scan_state = MODE_BSTAR;
            end else if (b == CHAR_SLASH) begin
               scan_state = MODE_BSLASH;
            end else begin
               scan_state = MODE_BLOCK;
            end
         end
      endcase
      if (!closed && eot) begin
         closed = 1'b1;
         if (scan_state == MODE_BLOCK || scan_state == MODE_BSTAR
             || scan_state == MODE_BSLASH) st = ST_UNTERM;
         else if (scan_state == MODE_SLASH) st = ST_CONTENT;
         else st = ST_EOT;
      end
      if (!closed) return 1'b0;
      r.count    = SKIP_WIDTH'(skip_tally);
      r.status   = st;
      scan_state = MODE_IDLE;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   task automatic append_byte(input logic [7:0] b);
      run_bytes.insert(run_bytes.size(), b);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] content_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((b >= WS_LOW && b <= WS_HIGH) || b == CHAR_SLASH);
      return b;
   endfunction

   task automatic add_word(input logic [7:0] b, input logic br, input logic eot);
      text_word_type w;
      w.word.text_byte   = b;
      w.word.begin_run   = br;
      w.word.end_of_text = eot;
      w.gap              = burst ? 0 : pick_gap();
      pending_words.insert(pending_words.size(), w);
   endtask

   // queue the collected bytes as one run: begin on the first, optional end on the last
   task automatic push_run(input bit eot_last);
      foreach (run_bytes[i])
         add_word(run_bytes[i], i == 0, eot_last && i == run_bytes.size() - 1);
      run_bytes.delete();
   endtask

   task automatic add_run(input string s, input bit eot_last);
      run_bytes.delete();
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
      push_run(eot_last);
   endtask

   // body bytes that neither close the comment nor open a nested one
   task automatic add_block_body(input int n);
      logic [7:0] b;
      logic [7:0] prev;
      prev = WS_HIGH;
      repeat (n) begin
         do b = ($urandom_range(0, 3) == 0) ? CHAR_STAR : 8'($urandom_range(0, 255));
         while ((prev == CHAR_SLASH && b == CHAR_STAR) || (prev == CHAR_STAR && b == CHAR_SLASH));
         append_byte(b);
         prev = b;
      end
   endtask

   task automatic add_line_body(input int n);
      logic [7:0] b;
      repeat (n) begin
         do b = 8'($urandom_range(0, 255)); while (b == CHAR_NEWLINE);
         append_byte(b);
      end
   endtask

   task automatic add_random_run();
      logic [7:0] b;
      bit         eot_last;
      eot_last = 1'b0;
      run_bytes.delete();
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(WS_LOW, WS_HIGH)));
            1: begin
               append_byte(CHAR_SLASH);
               append_byte(CHAR_SLASH);
               add_line_body($urandom_range(0, 5));
               append_byte(CHAR_NEWLINE);
            end
            default: begin
               append_byte(CHAR_SLASH);
               append_byte(CHAR_STAR);
               add_block_body($urandom_range(0, 6));
               if (run_bytes[$] == CHAR_SLASH) append_byte(WS_HIGH);
               append_byte(CHAR_STAR);
               append_byte(CHAR_SLASH);
            end
         endcase
      end
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            append_byte(content_byte());
            eot_last = ($urandom_range(0, 7) == 0);
         end
         3: begin
            if (run_bytes.size() == 0) append_byte(WS_LOW);
            eot_last = 1'b1;
         end
         4: begin
            // lone slash followed by anything but an opener
            append_byte(CHAR_SLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_STAR || b == CHAR_SLASH);
            append_byte(b);
         end
         5: begin
            append_byte(CHAR_SLASH);
            eot_last = 1'b1;
         end
         6: begin
            append_byte(CHAR_SLASH);
            append_byte(CHAR_STAR);
            add_block_body($urandom_range(0, 6));
            if (run_bytes[$] == CHAR_STAR) append_byte(WS_HIGH);
            if (run_bytes[$] != CHAR_SLASH) append_byte(CHAR_SLASH);
            append_byte(CHAR_STAR);
         end
         7: begin
            append_byte(CHAR_SLASH);
            append_byte(CHAR_STAR);
            add_block_body($urandom_range(0, 6));
            eot_last = 1'b1;
         end
         8: begin
            append_byte(CHAR_SLASH);
            append_byte(CHAR_SLASH);
            add_line_body($urandom_range(0, 5));
            eot_last = 1'b1;
         end
         default: begin
            // left open, the next begin drops it
            if (run_bytes.size() == 0) append_byte(WS_HIGH);
         end
      endcase
      burst = ($urandom_range(0, 4) == 0);
      push_run(eot_last);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
   endtask

   // ---------------------------------------------------------------- stimulus and end of run

   initial begin : stimulus
      int target;

      add_run("\n!", 1'b0);
      add_run("/**/!", 1'b0);
      add_run("//\n", 1'b0);
      add_word(8'h00, 1'b0, 1'b0);
      add_run("  ", 1'b0);
      add_run("/!", 1'b0);
      add_run("/", 1'b1);
      add_run("/*/*", 1'b0);
      add_run("/**", 1'b1);
      add_word(WS_LOW, 1'b1, 1'b1);
      add_run("//", 1'b1);
      add_word(8'hFF, 1'b1, 1'b1);
      add_word(WS_HIGH, 1'b0, 1'b1);
      add_run(" /", 1'b1);

      target = pending_words.size() + RANDOM_WORDS;
      while (pending_words.size() < target) begin
         if ($urandom_range(0, 9) == 0) begin
            burst = 1'b0;
            repeat ($urandom_range(1, 6))
               add_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                        $urandom_range(0, 7) == 0);
         end else begin
            add_random_run();
         end
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : drive_words
      text_word_type w;
      if (!reset && (!req_valid || word_taken)) begin
         if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_spent < pending_words[0].gap) begin
            idle_spent++;
            req_valid <= 1'b0;
         end else begin
            w = pending_words.pop_front();
            idle_spent = 0;
            req_valid       <= 1'b1;
            req_text_byte   <= w.word.text_byte;
            req_begin_run   <= w.word.begin_run;
            req_end_of_text <= w.word.end_of_text;
         end
      end
   end

   // result side: random stalls, calm stretches and one long hold to back up the pipe
   always @(negedge clock) begin : drive_ready
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_words >= 60) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (steady_left > 0) steady_left--;
         else if ($urandom_range(0, 19) == 0) steady_left = $urandom_range(30, 100);
         else stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : check_results
      skip_result_type predicted;
      skip_result_type oldest;
      if (reset) begin
         scan_state = MODE_IDLE;
         skip_tally = 0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_words++;
            if (scan_byte(req_text_byte, req_begin_run, req_end_of_text, predicted))
               awaited_results.insert(awaited_results.size(), predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with none awaited", rsp_skipped_count, 0);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_skipped_count !== oldest.count)
                  report_mismatch("skipped_count", rsp_skipped_count, oldest.count);
               if (rsp_run_status !== oldest.status)
                  report_mismatch("run_status", rsp_run_status, oldest.status);
            end
         end
      end
      word_taken <= !reset && req_valid && req_ready;
   end

endmodule
